// File: hw/rtl/poi_pkg.sv
// ----------------------------------------------------------------------------
// Planar odometry integrator package
// Payload types, sequencer codes and fixed-point constants for the integrator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package poi_pkg;

    localparam int CORDIC_STAGES_DEF = 16;
    localparam int POS_WIDTH         = 48;

    // input transfer
    typedef struct packed {
        logic signed [15:0] vel_x;
        logic signed [15:0] vel_y;
        logic signed [15:0] yaw_rate;
        logic        [19:0] elapsed_us;
    } t_in;

    // output transfer
    typedef struct packed {
        logic signed [POS_WIDTH-1:0] pos_x;
        logic signed [POS_WIDTH-1:0] pos_y;
        logic        [31:0]          heading;
        logic                        saturated;
    } t_out;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CORDIC,
        ST_MATH,
        ST_WAIT
    } t_state;

    // multiplier program; a step may issue one product and may consume the one issued by the step before
    typedef enum logic [4:0] {
        MS_M_MUL,
        MS_P_MUL,
        MS_Q_MUL,
        MS_YL_MUL,
        MS_QC_MUL,
        MS_YH_MUL,
        MS_TQ_MUL,
        MS_XC_MUL,
        MS_YS_MUL,
        MS_YC_MUL,
        MS_XS_MUL,
        MS_WX_ABS,
        MS_XL_MUL,
        MS_XH_MUL,
        MS_WY_ABS,
        MS_PX_ADD,
        MS_PYH_MUL,
        MS_DY_RND,
        MS_PY_ADD
    } t_mstep;

    // CORDIC datapath, Q2.30 vectors with headroom
    localparam int CORDIC_W = 34;
    localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN  = 34'sd652032874;
    localparam logic signed [CORDIC_W-1:0] QUARTER_TURN = 34'sd1073741824;
    localparam logic signed [CORDIC_W-1:0] HALF_TURN    = 34'sd2147483648;

    localparam logic [31:0] ATAN_TAB [32] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,
        32'd41,        32'd20,        32'd10,        32'd5,
        32'd3,         32'd1,         32'd1,         32'd0
    };

    // shared multiplier operand widths (signed)
    localparam int MUL_A_W = 41;
    localparam int MUL_B_W = 25;

    // time factor tq = el*TQ_INT_MUL + floor((el*TQ_FRAC_MUL + TQ_FRAC_ADD) / TQ_DIV)
    localparam int TQ_INT_MUL   = 274877;
    localparam int TQ_FRAC_MUL  = 14171;
    localparam int TQ_FRAC_ADD  = 7812;
    localparam int TQ_DIV       = 15625;
    localparam int TQ_RECIP     = 1099511;   // floor(2^34 / 15625)
    localparam int TQ_RECIP_SH  = 34;
    localparam int TQ_W         = 39;

    localparam int YAW_SCALE    = 716770142;

    localparam int VEL_ACC_W    = 50;
    localparam int MAG_W        = 48;
    localparam int DMAG_W       = 24;

    localparam logic [63:0] RND_HALF_32 = 64'h0000_0000_8000_0000;
    localparam logic [63:0] RND_HALF_64 = 64'h8000_0000_0000_0000;

endpackage

// File: hw/rtl/planar_odometry_integrator.sv
// CORDIC shift-add loop, then a 19-step program on one shared multiplier; the input
// stalls from its transfer until the result enters the output register.
// Output register lets the next item start while a result waits to be taken.
// Reset (synchronous, active low) clears position, heading and all control state.
// ----------------------------------------------------------------------------
// Planar odometry integrator
// Dead reckoning: rotates body velocity by the heading, scales by elapsed
// time, accumulates saturating world position and advances the heading.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module planar_odometry_integrator #(
    parameter int CORDIC_STAGES = poi_pkg::CORDIC_STAGES_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  poi_pkg::t_in  i_data,
    output logic          o_valid,
    input  logic          i_stall,
    output poi_pkg::t_out o_data
);
    import poi_pkg::*;

    localparam logic [4:0] LAST_ITER = 5'(CORDIC_STAGES - 1);

    // ------------------------------------------------------------------
    // Control
    // ------------------------------------------------------------------
    t_state r_state, n_state;
    t_mstep r_step;
    logic [4:0] r_cnt;          // CORDIC iteration, also the arctangent index
    logic r_out_valid;
    logic accept;
    logic out_load;

    // ------------------------------------------------------------------
    // Datapath registers
    // ------------------------------------------------------------------
    t_in r_in;
    logic signed [CORDIC_W-1:0] r_x, r_y, r_z;
    logic r_flip;               // heading was folded by a half turn

    logic [63:0] r_prod;        // registered multiplier output
    logic [63:0] r_acc;         // rounding / partial product accumulator
    logic [33:0] r_m;           // fractional part numerator of tq
    logic [35:0] r_p;           // |yaw_rate| * elapsed_us
    logic [19:0] r_q;
    logic [31:0] r_dyaw;        // heading step magnitude
    logic [TQ_W-1:0] r_tq;
    logic signed [VEL_ACC_W-1:0] r_wx, r_wy;
    logic [MAG_W-1:0] r_mag;
    logic r_neg;
    logic [DMAG_W-1:0] r_dmag;
    logic r_dneg;

    logic signed [POS_WIDTH-1:0] r_px, r_py;
    logic [31:0] r_yaw;
    logic r_sat;
    t_out r_out;

    // ------------------------------------------------------------------
    // FSM: next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (accept) n_state = ST_CORDIC;
            ST_CORDIC: if (r_cnt == LAST_ITER) n_state = ST_MATH;
            ST_MATH:   if (r_step == MS_PY_ADD) n_state = ST_WAIT;
            ST_WAIT:   if (out_load) n_state = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // FSM: outputs
    // ------------------------------------------------------------------
    always_comb begin
        o_stall  = 1'b1;
        accept   = 1'b0;
        out_load = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_stall = 1'b0;
                accept  = i_valid;
            end
            ST_CORDIC, ST_MATH: begin
            end
            ST_WAIT: begin
                // hand the result over once the output register is free
                out_load = !r_out_valid || !i_stall;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= MS_M_MUL;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_cnt <= '0;
            end else if (r_state == ST_CORDIC) begin
                r_cnt <= r_cnt + 5'd1;
            end
            if (r_state == ST_CORDIC) begin
                r_step <= MS_M_MUL;
            end else if (r_state == ST_MATH) begin
                r_step <= t_mstep'(r_step + 5'd1);
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // CORDIC: fold heading into +-quarter turn, then rotation-mode iterations
    // ------------------------------------------------------------------
    logic signed [CORDIC_W-1:0] z_raw, z_fold;
    logic fold;
    logic signed [CORDIC_W-1:0] xs, ys, atan_k;

    always_comb begin
        z_raw  = CORDIC_W'($signed(r_yaw));
        z_fold = z_raw;
        fold   = 1'b0;
        if (z_raw > QUARTER_TURN) begin
            z_fold = z_raw - HALF_TURN;
            fold   = 1'b1;
        end else if (z_raw < -QUARTER_TURN) begin
            z_fold = z_raw + HALF_TURN;
            fold   = 1'b1;
        end
    end

    assign xs     = r_x >>> r_cnt;
    assign ys     = r_y >>> r_cnt;
    assign atan_k = $signed({2'b00, ATAN_TAB[r_cnt]});

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in   <= i_data;
            r_x    <= CORDIC_GAIN;
            r_y    <= '0;
            r_z    <= z_fold;
            r_flip <= fold;
        end else if (r_state == ST_CORDIC) begin
            if (!r_z[CORDIC_W-1]) begin
                r_x <= r_x - ys;
                r_y <= r_y + xs;
                r_z <= r_z - atan_k;
            end else begin
                r_x <= r_x + ys;
                r_y <= r_y - xs;
                r_z <= r_z + atan_k;
            end
        end
    end

    // ------------------------------------------------------------------
    // Shared multiplier: operands chosen by the program step, product
    // registered and consumed by the following step.
    // ------------------------------------------------------------------
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MUL_A_W+MUL_B_W-1:0] mul_p;
    logic [15:0] wz_mag;

    assign wz_mag = r_in.yaw_rate[15] ? 16'(-r_in.yaw_rate) : 16'(r_in.yaw_rate);

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_step)
            MS_M_MUL: begin
                mul_a = MUL_A_W'(r_in.elapsed_us);
                mul_b = MUL_B_W'(TQ_FRAC_MUL);
            end
            MS_P_MUL: begin
                mul_a = MUL_A_W'(r_in.elapsed_us);
                mul_b = MUL_B_W'(wz_mag);
            end
            MS_Q_MUL: begin
                mul_a = MUL_A_W'(r_m);
                mul_b = MUL_B_W'(TQ_RECIP);
            end
            MS_YL_MUL: begin
                mul_a = MUL_A_W'(YAW_SCALE);
                mul_b = MUL_B_W'(r_p[23:0]);
            end
            MS_QC_MUL: begin
                mul_a = MUL_A_W'(r_q);
                mul_b = MUL_B_W'(TQ_DIV);
            end
            MS_YH_MUL: begin
                mul_a = MUL_A_W'(YAW_SCALE);
                mul_b = MUL_B_W'(r_p[35:24]);
            end
            MS_TQ_MUL: begin
                mul_a = MUL_A_W'(r_in.elapsed_us);
                mul_b = MUL_B_W'(TQ_INT_MUL);
            end
            MS_XC_MUL: begin
                mul_a = MUL_A_W'(r_x);
                mul_b = MUL_B_W'(r_in.vel_x);
            end
            MS_YS_MUL: begin
                mul_a = MUL_A_W'(r_y);
                mul_b = MUL_B_W'(r_in.vel_y);
            end
            MS_YC_MUL: begin
                mul_a = MUL_A_W'(r_y);
                mul_b = MUL_B_W'(r_in.vel_x);
            end
            MS_XS_MUL: begin
                mul_a = MUL_A_W'(r_x);
                mul_b = MUL_B_W'(r_in.vel_y);
            end
            MS_XL_MUL, MS_PX_ADD: begin
                mul_a = MUL_A_W'(r_tq);
                mul_b = MUL_B_W'(r_mag[23:0]);
            end
            MS_XH_MUL, MS_PYH_MUL: begin
                mul_a = MUL_A_W'(r_tq);
                mul_b = MUL_B_W'(r_mag[47:24]);
            end
            default: begin
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    always_ff @(posedge i_clk) begin
        r_prod <= 64'(mul_p);
    end

    // ------------------------------------------------------------------
    // Program consume side
    // ------------------------------------------------------------------
    logic signed [VEL_ACC_W-1:0] abs_src, abs_val;
    logic [DMAG_W-1:0] dmag_next;

    // |w| < 2^47, so the magnitude fits MAG_W bits
    assign abs_src   = (r_step == MS_WX_ABS) ? r_wx : r_wy;
    assign abs_val   = abs_src[VEL_ACC_W-1] ? -abs_src : abs_src;
    // round(|w| * tq / 2^64) from hi and lo partial products
    assign dmag_next = DMAG_W'((r_prod + (r_acc >> 24)) >> 40);

    always_ff @(posedge i_clk) begin
        if (r_state == ST_MATH) begin
            unique case (r_step)
                MS_P_MUL:  r_m <= 34'(r_prod) + 34'(TQ_FRAC_ADD);
                MS_Q_MUL:  r_p <= 36'(r_prod);
                MS_YL_MUL: r_q <= 20'(r_prod >> TQ_RECIP_SH);
                MS_QC_MUL: r_acc <= r_prod + RND_HALF_32;
                MS_YH_MUL: begin
                    // reciprocal estimate is low by at most one
                    if ((r_m - 34'(r_prod)) >= 34'(TQ_DIV)) begin
                        r_q <= r_q + 20'd1;
                    end
                end
                MS_TQ_MUL: r_dyaw <= 32'((r_prod + (r_acc >> 24)) >> 8);
                MS_XC_MUL: r_tq <= TQ_W'(r_prod) + TQ_W'(r_q);
                MS_YS_MUL: r_wx <= VEL_ACC_W'($signed(r_prod));
                MS_YC_MUL: r_wx <= r_wx - VEL_ACC_W'($signed(r_prod));
                MS_XS_MUL: r_wy <= VEL_ACC_W'($signed(r_prod));
                MS_WX_ABS: begin
                    r_wy  <= r_wy + VEL_ACC_W'($signed(r_prod));
                    r_mag <= MAG_W'(abs_val);
                    r_neg <= r_wx[VEL_ACC_W-1] ^ r_flip;
                end
                MS_XH_MUL: r_acc <= r_prod + RND_HALF_64;
                MS_WY_ABS: begin
                    r_dmag <= dmag_next;
                    r_dneg <= r_neg;
                    r_mag  <= MAG_W'(abs_val);
                    r_neg  <= r_wy[VEL_ACC_W-1] ^ r_flip;
                end
                MS_PYH_MUL: r_acc <= r_prod + RND_HALF_64;
                MS_DY_RND: begin
                    r_dmag <= dmag_next;
                    r_dneg <= r_neg;
                end
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Saturating position update and heading advance
    // ------------------------------------------------------------------
    localparam logic signed [POS_WIDTH-1:0] PMAX = {1'b0, {(POS_WIDTH-1){1'b1}}};
    localparam logic signed [POS_WIDTH-1:0] PMIN = {1'b1, {(POS_WIDTH-1){1'b0}}};

    logic signed [POS_WIDTH-1:0] sat_p, sat_res;
    logic signed [POS_WIDTH:0]   sat_sum, sat_d;
    logic sat_ovf;
    logic [31:0] yaw_delta;

    assign sat_p   = (r_step == MS_PY_ADD) ? r_py : r_px;
    assign sat_d   = (POS_WIDTH+1)'(r_dmag);
    assign sat_sum = r_dneg ? ({sat_p[POS_WIDTH-1], sat_p} - sat_d)
                            : ({sat_p[POS_WIDTH-1], sat_p} + sat_d);
    assign sat_ovf = sat_sum[POS_WIDTH] != sat_sum[POS_WIDTH-1];
    assign sat_res = sat_ovf ? (sat_sum[POS_WIDTH] ? PMIN : PMAX)
                             : sat_sum[POS_WIDTH-1:0];

    assign yaw_delta = r_in.yaw_rate[15] ? (32'd0 - r_dyaw) : r_dyaw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_px  <= '0;
            r_py  <= '0;
            r_yaw <= '0;
            r_sat <= 1'b0;
        end else begin
            if (accept) begin
                r_sat <= 1'b0;
            end
            if (r_state == ST_MATH && r_step == MS_PX_ADD) begin
                r_px  <= sat_res;
                r_sat <= r_sat | sat_ovf;
            end
            // heading moves only after both coordinates used the old one
            if (r_state == ST_MATH && r_step == MS_PY_ADD) begin
                r_py  <= sat_res;
                r_sat <= r_sat | sat_ovf;
                r_yaw <= r_yaw + yaw_delta;
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out.pos_x     <= r_px;
            r_out.pos_y     <= r_py;
            r_out.heading   <= r_yaw;
            r_out.saturated <= r_sat;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_accept_starts_cordic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> (r_state == ST_CORDIC && r_cnt == 5'd0))
        else $error("transfer did not start a CORDIC pass");

    a_recip_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MATH && r_step == MS_YH_MUL) |->
        (34'(r_prod) <= r_m && (r_m - 34'(r_prod)) < 34'(2 * TQ_DIV)))
        else $error("tq quotient estimate out of correction range");

    a_yaw_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_state == ST_MATH && r_step == MS_PY_ADD) |=> $stable(r_yaw))
        else $error("heading changed outside its update step");

    a_out_heading: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> (o_data.heading == r_yaw))
        else $error("result heading differs from stored heading");

endmodule

// File: verif/tb_top.sv
// ----------------------------------------------------------------------------
// Planar odometry integrator testbench
// Feeds odometry ticks through the valid/stall input channel and compares each
// pose transfer field by field against a bit-exact dead-reckoning predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
    import poi_pkg::*;

    // predictor constants, kept apart from the package so a bad table there is caught
    localparam int     STAGES    = 16;
    localparam longint GAIN_Q30  = 64'sd652032874;
    localparam longint QTR_TURN  = 64'sd1073741824;
    localparam longint HALF_TURN = 64'sd2147483648;
    localparam longint YAW_MULT  = 64'sd716770142;   // 2^52 / (2*pi*1e6)
    localparam longint ATAN_LUT [32] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
        83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
        81, 41, 20, 10, 5, 3, 1, 1, 0
    };

    // Longest run of cycles with no transfer on either side in a correct run:
    // a sender gap (67 percent idle), the processing of one tick, and a receiver
    // stall tail. QUIET_LIMIT leaves a wide margin.
    localparam int QUIET_LIMIT = 4000;
    localparam int TICKS_PER_PHASE = 175;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    t_in  i_data  = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    t_out o_data;

    planar_odometry_integrator #(
        .CORDIC_STAGES(STAGES)
    ) u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_data (i_data),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_data (o_data)
    );

    always #10 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Dead-reckoning predictor: its own copy of pose and heading
    // ------------------------------------------------------------------------
    longint      odo_x       = 0;
    longint      odo_y       = 0;
    logic [31:0] odo_heading = '0;

    t_out pending_poses [$];
    int   mismatches  = 0;
    int   quiet_cycles = 0;
    int   tx_idle_pct = 0;
    int   rx_stall_pct = 0;

    typedef struct {
        t_in stim;
        bit  zero_pose;   // pose is trivially all zero; typed in, not predicted
    } tick_row_t;

    tick_row_t directed_rows [$];

    // Q2.30 cosine/sine of a binary angle, rotation-mode CORDIC with quadrant fold
    function automatic void heading_cos_sin(input logic [31:0] ang,
                                            output longint cos_q,
                                            output longint sin_q);
        longint z, x, y, xs, ys;
        bit     flip;
        int     k;
        z    = longint'($signed(ang));
        x    = GAIN_Q30;
        y    = 0;
        flip = 1'b0;
        if (z > QTR_TURN) begin
            z    = z - HALF_TURN;
            flip = 1'b1;
        end else if (z < -QTR_TURN) begin
            z    = z + HALF_TURN;
            flip = 1'b1;
        end
        for (int i = 0; i < STAGES; i++) begin
            k  = i % 32;
            xs = x >>> k;
            ys = y >>> k;
            if (z >= 0) begin
                x = x - ys;
                y = y + xs;
                z = z - ATAN_LUT[k];
            end else begin
                x = x + ys;
                y = y - xs;
                z = z + ATAN_LUT[k];
            end
        end
        cos_q = flip ? -x : x;
        sin_q = flip ? -y : y;
    endfunction

    // round(|v| * f / 2^sh) half up on the magnitude, sign of v restored
    function automatic longint scale_round(input longint v, input logic [63:0] f,
                                           input int sh);
        logic [63:0]  mag;
        logic [127:0] prod;
        longint       r;
        mag  = (v < 0) ? 64'(-v) : 64'(v);
        prod = {64'b0, mag} * {64'b0, f};
        prod = (prod + (128'd1 << (sh - 1))) >> sh;
        r    = longint'(prod[63:0]);
        return (v < 0) ? -r : r;
    endfunction

    // saturating add at the signed pose width
    function automatic longint clip_add(input longint p, input longint d, inout bit sat);
        longint pmax, pmin;
        pmax = (64'sd1 <<< (POS_WIDTH - 1)) - 1;
        pmin = -pmax - 1;
        if (d > 0 && p > pmax - d) begin
            sat = 1'b1;
            return pmax;
        end
        if (d < 0 && p < pmin - d) begin
            sat = 1'b1;
            return pmin;
        end
        return p + d;
    endfunction

    // one tick: move with the heading held before the tick, then turn
    function automatic t_out integrate_tick(input t_in tick);
        longint      vx, vy, wz, el, c, s, wx, wy, dth;
        logic [63:0] tq;
        bit          sat;
        t_out        pose;
        vx  = longint'($signed(tick.vel_x));
        vy  = longint'($signed(tick.vel_y));
        wz  = longint'($signed(tick.yaw_rate));
        el  = longint'({44'b0, tick.elapsed_us});
        tq  = ((64'(el) << 38) + 64'd500000) / 64'd1000000;
        sat = 1'b0;
        heading_cos_sin(odo_heading, c, s);
        wx = vx * c - vy * s;
        wy = vx * s + vy * c;
        odo_x = clip_add(odo_x, scale_round(wx, tq, 64), sat);
        odo_y = clip_add(odo_y, scale_round(wy, tq, 64), sat);
        dth = scale_round(wz * el, 64'(YAW_MULT), 32);
        odo_heading = odo_heading + dth[31:0];   // wraps at one full turn
        pose.pos_x     = odo_x[POS_WIDTH-1:0];
        pose.pos_y     = odo_y[POS_WIDTH-1:0];
        pose.heading   = odo_heading;
        pose.saturated = sat;
        return pose;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic add_row(input int vx, input int vy, input int wz, input int el,
                           input bit zero_pose);
        tick_row_t row;
        row.stim.vel_x      = vx[15:0];
        row.stim.vel_y      = vy[15:0];
        row.stim.yaw_rate   = wz[15:0];
        row.stim.elapsed_us = el[19:0];
        row.zero_pose       = zero_pose;
        directed_rows.push_back(row);
    endtask

    // velocity: extremes and small values often, full range otherwise
    function automatic logic [15:0] pick_vel();
        case ($urandom_range(7))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'h0000;
            3: return 16'($signed($urandom_range(128)) - 64);
            default: return 16'($urandom);
        endcase
    endfunction

    // Drives one tick, holds it until the transfer, then records the expected pose.
    // Entered and left in the time step of an edge; i_valid gets one update per step.
    task automatic send_tick(input t_in tick, input bit zero_pose);
        t_out want;
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= tick;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        want = integrate_tick(tick);
        if (zero_pose) want = '0;
        pending_poses.push_back(want);
    endtask

    // ------------------------------------------------------------------------
    // Receiver: random stall per phase
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < rx_stall_pct);
    end

    // ------------------------------------------------------------------------
    // Result checker; values read right after the edge are the pre-edge ones
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_poses.size() == 0) begin
                $error("unexpected pose transfer: pos_x %0d pos_y %0d heading %0d",
                       o_data.pos_x, o_data.pos_y, o_data.heading);
                mismatches++;
            end else begin
                want = pending_poses.pop_front();
                if (o_data.pos_x !== want.pos_x) begin
                    $error("pos_x expected %0d got %0d", want.pos_x, o_data.pos_x);
                    mismatches++;
                end
                if (o_data.pos_y !== want.pos_y) begin
                    $error("pos_y expected %0d got %0d", want.pos_y, o_data.pos_y);
                    mismatches++;
                end
                if (o_data.heading !== want.heading) begin
                    $error("heading expected %0d got %0d", want.heading, o_data.heading);
                    mismatches++;
                end
                if (o_data.saturated !== want.saturated) begin
                    $error("saturated expected %0d got %0d",
                           want.saturated, o_data.saturated);
                    mismatches++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: too long without any transfer means the block hung
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[planar_odometry_integrator] ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        t_in tick;

        // Directed ticks. The first three leave the pose at zero: zero elapsed
        // time at both velocity extremes, then a full-length tick with no motion.
        add_row( 32767,  32767,  32767,       0, 1'b1);
        add_row(-32768, -32768, -32768,       0, 1'b1);
        add_row(     0,      0,      0, 1048575, 1'b1);
        // straight moves at heading zero, both axes, both signs
        add_row( 32767,      0,      0,    1000, 1'b0);
        add_row(     0,  32767,      0,    1000, 1'b0);
        add_row(-32768, -32768,      0, 1048575, 1'b0);
        add_row(     1,     -1,      1,       1, 1'b0);
        add_row( 32767,      0,      0,       1, 1'b0);
        // fast turn past a full revolution: heading wraps upward
        add_row(     0,      0,  32767, 1048575, 1'b0);
        // move and turn in one tick: the move uses the heading from before
        add_row( 32767,      0,  32767, 1048575, 1'b0);
        add_row(     0,  32767,  32767,  500000, 1'b0);
        // turn the other way through zero: heading wraps downward
        add_row(     0,      0, -32768, 1048575, 1'b0);
        add_row(     0,      0, -32768, 1048575, 1'b0);
        add_row(-32768,  32767, -32768, 1048575, 1'b0);
        // zero elapsed time mid-run: pose held, result still produced
        add_row( 32767,  32767,  32767,       0, 1'b0);
        // steer to near a half turn, then a quarter turn, and move there
        add_row(     0,      0,  32767,  392700, 1'b0);
        add_row( 32767,  32767,      0,  250000, 1'b0);
        add_row(     0,      0, -32768,  196350, 1'b0);
        add_row(-32768,  32767,      0,  250000, 1'b0);
        add_row(  4096,  -4096,   4096,  999999, 1'b0);
        add_row( 21845, -21846, -21846,  699050, 1'b0);
        // Position saturation needs on the order of 1e8 full-speed ticks from
        // reset, out of reach of a bounded run; the predictor still models it.

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[r]) send_tick(directed_rows[r].stim, directed_rows[r].zero_pose);

        // Random ticks in four idling phases. Each phase starts with the sender
        // held off until every pose is back, so the block is drained between them.
        for (int ph = 0; ph < 4; ph++) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while (pending_poses.size() != 0);
            case (ph)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 67; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 67; end
                default: begin tx_idle_pct = 28; rx_stall_pct = 28; end
            endcase
            for (int n = 0; n < TICKS_PER_PHASE; n++) begin
                tick.vel_x    = pick_vel();
                tick.vel_y    = pick_vel();
                tick.yaw_rate = pick_vel();
                case ($urandom_range(7))
                    0:       tick.elapsed_us = '0;
                    1:       tick.elapsed_us = 20'hFFFFF;
                    2, 3:    tick.elapsed_us = 20'($urandom_range(2000));
                    default: tick.elapsed_us = 20'($urandom_range(20'hFFFFF));
                endcase
                send_tick(tick, 1'b0);
            end
        end

        // drain, then allow a latency's worth of cycles for any stray transfer
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_poses.size() != 0);
        repeat (STAGES + 24) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("[planar_odometry_integrator] OK");
        end else begin
            $display("[planar_odometry_integrator] ERROR");
        end
        $finish;
    end

endmodule

// File: planar_odometry_integrator.f
hw/rtl/poi_pkg.sv
hw/rtl/planar_odometry_integrator.sv
verif/tb_top.sv
